### rtl/mjdcal_pkg.sv
// Shared types, constants and tables of the MJD to calendar converter.
package mjdcal_pkg;

    // Julian Day Number offset plus the epoch shift of the cycle algorithm
    localparam logic [21:0] JD_BIAS      = 22'd2432045;
    // Start of the 400-year cycle number 17, and of cycle 16
    localparam logic [21:0] CYC17_START  = 22'd2483649;
    localparam logic [21:0] CYC16_START  = 22'd2337552;
    // 400 * cycle - 4800 for cycles 16 and 17
    localparam logic [11:0] YEAR_BASE_16 = 12'd1600;
    localparam logic [11:0] YEAR_BASE_17 = 12'd2000;

    localparam logic [17:0] DAYS_100Y    = 18'd36524;
    localparam logic [15:0] DAYS_4Y      = 16'd1461;
    localparam logic [10:0] DAYS_1Y      = 11'd365;

    // Reciprocals for constant division: floor(x / n) = (x * RECIP) >> SHIFT
    localparam logic [11:0] RECIP_60     = 12'd2185;   // shift 17, x < 4096
    localparam logic [15:0] RECIP_1461   = 16'd45934;  // shift 26, x <= 36524
    localparam logic [12:0] RECIP_153    = 13'd6854;   // shift 20, x < 4096

    // Bias that makes the minute sum non-negative: 18 hours of minutes
    localparam logic signed [12:0] MIN_BIAS  = 13'sd1080;
    localparam logic [6:0]         HOUR_BIAS = 7'd18;

    typedef struct packed {
        logic [16:0]        mjd;
        logic [4:0]         utc_hour;
        logic [5:0]         utc_minute;
        logic [5:0]         utc_second;
        logic signed [10:0] offset_minutes;
    } ts_in_t;

    typedef struct packed {
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic signed [1:0] day_shift;
    } time_fields_t;

    typedef struct packed {
        logic [21:0]  jdn;
        time_fields_t tf;
    } adj_item_t;

    typedef struct packed {
        logic [11:0]  year;
        logic [3:0]   month;
        logic [4:0]   day;
        time_fields_t tf;
    } cal_item_t;

    // Day number of the first day of month m in a March-based year, plus 122
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] res;
        unique case (m)
            4'd0:    res = 9'd122;
            4'd1:    res = 9'd153;
            4'd2:    res = 9'd183;
            4'd3:    res = 9'd214;
            4'd4:    res = 9'd244;
            4'd5:    res = 9'd275;
            4'd6:    res = 9'd306;
            4'd7:    res = 9'd336;
            4'd8:    res = 9'd367;
            4'd9:    res = 9'd397;
            4'd10:   res = 9'd428;
            4'd11:   res = 9'd459;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

### rtl/mjdcal_time_adj.sv
// Two-stage time offset pipeline: minute wrap, hour wrap, day shift, JDN.
module mjdcal_time_adj import mjdcal_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      show_utc,
    input  logic      in_valid,
    output logic      in_ready,
    input  ts_in_t    in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output adj_item_t out_item
);

    logic [1:0] v_reg;
    logic [1:0] ld;

    assign ld[1]    = !v_reg[1] || out_ready;
    assign ld[0]    = !v_reg[0] || ld[1];
    assign in_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            if (ld[1]) begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // Stage 1: floor-divide the biased minute sum by 60
    logic signed [12:0] msum;
    logic [11:0]        ubias;
    logic [23:0]        qprod;
    logic [5:0]         quot;
    logic [11:0]        rem_w;

    assign msum  = $signed({7'd0, in_item.utc_minute})
                 + $signed({{2{in_item.offset_minutes[10]}}, in_item.offset_minutes})
                 + MIN_BIAS;
    assign ubias = msum[11:0];
    assign qprod = 24'(ubias) * 24'(RECIP_60);
    assign quot  = qprod[22:17];
    assign rem_w = ubias - ({quot, 6'd0} - {4'd0, quot, 2'd0});

    logic [5:0]  q1_reg;
    logic [5:0]  r1_reg;
    logic [16:0] mjd1_reg;
    logic [4:0]  uh1_reg;
    logic [5:0]  um1_reg;
    logic [5:0]  us1_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            q1_reg   <= quot;
            r1_reg   <= rem_w[5:0];
            mjd1_reg <= in_item.mjd;
            uh1_reg  <= in_item.utc_hour;
            um1_reg  <= in_item.utc_minute;
            us1_reg  <= in_item.utc_second;
        end
    end

    // Stage 2: one hour correction, day shift, choose clock, form JDN
    logic signed [6:0] lh_raw;
    logic [6:0]        lh;
    logic signed [1:0] shift;
    logic [21:0]       jdn_next;

    assign lh_raw = $signed({2'd0, uh1_reg}) + $signed({1'b0, q1_reg}) - $signed(HOUR_BIAS);

    always_comb begin
        if (lh_raw > 7'sd23) begin
            lh    = 7'(lh_raw - 7'sd24);
            shift = 2'sd1;
        end else if (lh_raw < 7'sd0) begin
            lh    = 7'(lh_raw + 7'sd24);
            shift = -2'sd1;
        end else begin
            lh    = 7'(lh_raw);
            shift = 2'sd0;
        end
    end

    assign jdn_next = 22'(mjd1_reg) + JD_BIAS
                    + (show_utc ? 22'd0 : {{20{shift[1]}}, shift});

    adj_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            out_reg.jdn          <= jdn_next;
            out_reg.tf.hour      <= show_utc ? uh1_reg : lh[4:0];
            out_reg.tf.minute    <= show_utc ? um1_reg : r1_reg;
            out_reg.tf.second    <= us1_reg;
            out_reg.tf.day_shift <= shift;
        end
    end

    assign out_valid = v_reg[1];
    assign out_item  = out_reg;

endmodule

### rtl/mjdcal_date_conv.sv
// Seven-stage Julian Day Number to Gregorian year, month and day pipeline.
module mjdcal_date_conv import mjdcal_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  adj_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output cal_item_t out_item
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] ld;
    time_fields_t    tf_reg [NSTG];

    always_comb begin
        ld[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end
    assign in_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            tf_reg[0] <= in_item.tf;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (ld[k]) begin
                tf_reg[k] <= tf_reg[k-1];
            end
        end
    end

    // Stage A: 400-year cycle (only cycles 16 and 17 are reachable)
    logic        cyc17;
    logic [21:0] dg_w;
    logic [17:0] dg_reg;
    logic [11:0] ya_reg;

    assign cyc17 = in_item.jdn >= CYC17_START;
    assign dg_w  = in_item.jdn - (cyc17 ? CYC17_START : CYC16_START);

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            dg_reg <= dg_w[17:0];
            ya_reg <= cyc17 ? YEAR_BASE_17 : YEAR_BASE_16;
        end
    end

    // Stage B: century within the cycle, capped at 3
    logic [1:0]  cent;
    logic [17:0] cent_days;
    logic [11:0] cent_years;
    logic [17:0] dc_w;
    logic [15:0] dcb_reg;
    logic [11:0] yb_reg;

    assign cent = 2'(dg_reg >= DAYS_100Y)
                + 2'(dg_reg >= 18'(DAYS_100Y * 2))
                + 2'(dg_reg >= 18'(DAYS_100Y * 3));

    always_comb begin
        unique case (cent)
            2'd0:    begin cent_days = 18'd0;                cent_years = 12'd0;   end
            2'd1:    begin cent_days = DAYS_100Y;            cent_years = 12'd100; end
            2'd2:    begin cent_days = 18'(DAYS_100Y * 2);   cent_years = 12'd200; end
            default: begin cent_days = 18'(DAYS_100Y * 3);   cent_years = 12'd300; end
        endcase
    end

    assign dc_w = dg_reg - cent_days;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            dcb_reg <= dc_w[15:0];
            yb_reg  <= ya_reg + cent_years;
        end
    end

    // Stage C: four-year cycle by reciprocal multiply
    logic [31:0] bprod;
    logic [4:0]  quad_reg;
    logic [15:0] dcc_reg;
    logic [11:0] yc_reg;

    assign bprod = 32'(dcb_reg) * 32'(RECIP_1461);

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            quad_reg <= bprod[30:26];
            dcc_reg  <= dcb_reg;
            yc_reg   <= yb_reg;
        end
    end

    // Stage D: day within the four-year cycle
    logic [15:0] quad_days;
    logic [15:0] db_w;
    logic [10:0] db_reg;
    logic [11:0] yd_reg;

    assign quad_days = 16'(quad_reg) * DAYS_4Y;
    assign db_w      = dcc_reg - quad_days;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            db_reg <= db_w[10:0];
            yd_reg <= yc_reg + {5'd0, quad_reg, 2'd0};
        end
    end

    // Stage E: year within the four-year cycle, capped at 3
    logic [1:0]  yr;
    logic [10:0] yr_days;
    logic [10:0] da_w;
    logic [8:0]  dae_reg;
    logic [11:0] ye_reg;

    assign yr = 2'(db_reg >= DAYS_1Y)
              + 2'(db_reg >= 11'(DAYS_1Y * 2))
              + 2'(db_reg >= 11'(DAYS_1Y * 3));

    always_comb begin
        unique case (yr)
            2'd0:    yr_days = 11'd0;
            2'd1:    yr_days = DAYS_1Y;
            2'd2:    yr_days = 11'(DAYS_1Y * 2);
            default: yr_days = 11'(DAYS_1Y * 3);
        endcase
    end

    assign da_w = db_reg - yr_days;

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            dae_reg <= da_w[8:0];
            ye_reg  <= yd_reg + {10'd0, yr};
        end
    end

    // Stage F: March-based month from the day of year
    logic [11:0] mt;
    logic [24:0] mprod;
    logic [4:0]  mq;
    logic [4:0]  mm_w;
    logic [3:0]  mf_reg;
    logic [8:0]  daf_reg;
    logic [11:0] yf_reg;

    assign mt    = {1'b0, dae_reg, 2'd0} + 12'(dae_reg) + 12'd308;
    assign mprod = 25'(mt) * 25'(RECIP_153);
    assign mq    = mprod[24:20];
    assign mm_w  = mq - 5'd2;

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            mf_reg  <= mm_w[3:0];
            daf_reg <= dae_reg;
            yf_reg  <= ye_reg;
        end
    end

    // Stage G: day of month, calendar month and year carry
    logic        late;
    logic [9:0]  dom_w;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    assign late  = mf_reg >= 4'd10;
    assign dom_w = 10'(daf_reg) + 10'd123 - 10'(month_start(mf_reg));

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            year_reg  <= yf_reg + {11'd0, late};
            month_reg <= late ? 4'(mf_reg - 4'd9) : 4'(mf_reg + 4'd3);
            day_reg   <= dom_w[4:0];
        end
    end

    always_comb begin
        out_item.year  = year_reg;
        out_item.month = month_reg;
        out_item.day   = day_reg;
        out_item.tf    = tf_reg[NSTG-1];
    end

    assign out_valid = v_reg[NSTG-1];

endmodule

### rtl/mjd_time_to_local_calendar.sv
// Top level: broadcast time stamp to UTC or local calendar date and clock time.
//
// Converts one time stamp (Modified Julian Date, UTC hour/minute/second and a
// signed local offset in minutes) into year, month, day, hour, minute, second
// and the local-minus-UTC day shift. The converter is a nine-stage pipeline:
// two stages apply the offset (minute floor division by 60, one hour
// correction of 24, choice of clock and Julian Day Number), seven stages
// take the day number apart into 400-year, 100-year, 4-year and 1-year
// cycles and then into month and day. It accepts one item every clock cycle
// when the output side does not stall; the longest path per stage is one
// constant reciprocal multiply. Each stage has its own valid bit and loads
// when it is empty or when the next stage loads, so bubbles are squeezed
// out and a stall on m_tready holds every item in place. show_utc is
// written through the cfg channel (always ready) and should only change while
// no items are in flight; after reset the local clock is given.
module mjd_time_to_local_calendar import mjdcal_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel: show_utc
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // mjd[16:0], utc_hour[21:17], utc_minute[27:22], utc_second[33:28],
    // offset_minutes[44:34], zero fill[47:45]
    input  logic [47:0] s_tdata,

    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], day_shift[39:38]
    output logic [39:0] m_tdata
);

    // Hold the clock selection; the port never pushes back
    logic show_utc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_utc_reg <= 1'b0;
        end else if (cfg_valid) begin
            show_utc_reg <= cfg_data;
        end
    end

    // Unpack the input item
    ts_in_t in_item;

    assign in_item.mjd            = s_tdata[16:0];
    assign in_item.utc_hour       = s_tdata[21:17];
    assign in_item.utc_minute     = s_tdata[27:22];
    assign in_item.utc_second     = s_tdata[33:28];
    assign in_item.offset_minutes = $signed(s_tdata[44:34]);

    // Offset arithmetic and clock choice
    logic      adj_valid;
    logic      adj_ready;
    adj_item_t adj_item;

    mjdcal_time_adj u_time_adj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .show_utc  (show_utc_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (adj_valid),
        .out_ready (adj_ready),
        .out_item  (adj_item)
    );

    // Day number to calendar date; its last stage is the output register
    cal_item_t cal_item;

    mjdcal_date_conv u_date_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (adj_valid),
        .in_ready  (adj_ready),
        .in_item   (adj_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (cal_item)
    );

    // Pack the result item
    assign m_tdata = {cal_item.tf.day_shift, cal_item.tf.second, cal_item.tf.minute,
                      cal_item.tf.hour, cal_item.day, cal_item.month, cal_item.year};

endmodule
